[rtl/core/assert_macros.svh]
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/rhp_pkg.sv]
// shared types and constants of the rtp header parser
package rhp_pkg;

    localparam int MAX_DATAGRAM_LEN_DEF = 65535;
    localparam int HDR_BYTES = 12;
    localparam int EXT_W = 16;
    localparam int OFF_W = EXT_W + 3;
    localparam logic [1:0] RTP_VERSION = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_BAD_VERSION = 2'd2;

    typedef struct packed {
        logic [7:0]       first;
        logic [7:0]       second;
        logic [15:0]      seq;
        logic [31:0]      tstamp;
        logic [31:0]      ssrc;
        logic [EXT_W-1:0] ext_len;
        logic             overflow;
    } held_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        marker_bit;
        logic [6:0]  media_type;
        logic [15:0] sequence_res;
        logic [31:0] timestamp;
        logic [31:0] source_id;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } res_t;

endpackage

[rtl/core/rhp_capture.sv]
// byte counter and header field capture
module rhp_capture #(
    parameter int MAX_DATAGRAM_LEN = rhp_pkg::MAX_DATAGRAM_LEN_DEF,
    parameter int CNT_W = $clog2(MAX_DATAGRAM_LEN + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output rhp_pkg::held_t     hdr_now,
    output logic [CNT_W:0]     len_now
);
    import rhp_pkg::*;

    localparam int IDX_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W:0] MAX_LEN = (CNT_W + 1)'(MAX_DATAGRAM_LEN);

    held_t            hdr_reg;
    held_t            hdr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] ext_at;
    logic             len_over;
    logic             cap_en;

    assign len_now  = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign len_over = len_now > MAX_LEN;
    assign cap_en   = !hdr_reg.overflow && !len_over;
    assign idx      = IDX_W'(count_reg);
    assign ext_at   = IDX_W'(HDR_BYTES + 2) + IDX_W'({hdr_reg.first[3:0], 2'b00});

    always_comb
    begin
        hdr_now = hdr_reg;
        if (cap_en)
        begin
            if (idx == IDX_W'(0))
                hdr_now.first = data_byte;
            if (idx == IDX_W'(1))
                hdr_now.second = data_byte;
            if (idx >= IDX_W'(2) && idx <= IDX_W'(3))
                hdr_now.seq = {hdr_reg.seq[7:0], data_byte};
            if (idx >= IDX_W'(4) && idx <= IDX_W'(7))
                hdr_now.tstamp = {hdr_reg.tstamp[23:0], data_byte};
            if (idx >= IDX_W'(8) && idx <= IDX_W'(11))
                hdr_now.ssrc = {hdr_reg.ssrc[23:0], data_byte};
            if (idx >= IDX_W'(HDR_BYTES) && (idx == ext_at || idx == ext_at + IDX_W'(1)))
                hdr_now.ext_len = {hdr_reg.ext_len[EXT_W-9:0], data_byte};
        end
    end

    always_comb
    begin
        hdr_next   = hdr_reg;
        count_next = count_reg;
        if (step)
        begin
            if (last_byte)
            begin
                hdr_next   = '0;
                count_next = '0;
            end
            else
            begin
                hdr_next          = hdr_now;
                hdr_next.overflow = hdr_reg.overflow || len_over;
                if (!len_over)
                    count_next = len_now[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            hdr_reg   <= hdr_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/rhp_judge.sv]
// end-of-datagram checks and result fields
module rhp_judge #(
    parameter int MAX_DATAGRAM_LEN = rhp_pkg::MAX_DATAGRAM_LEN_DEF,
    parameter int CNT_W = $clog2(MAX_DATAGRAM_LEN + 1)
) (
    input  rhp_pkg::held_t hdr,
    input  logic [CNT_W:0] len,
    input  logic [7:0]     pad,
    output rhp_pkg::res_t  res
);
    import rhp_pkg::*;

    localparam logic [CNT_W:0] MAX_LEN = (CNT_W + 1)'(MAX_DATAGRAM_LEN);

    logic [OFF_W-1:0] len_x;
    logic [OFF_W-1:0] base_off;
    logic [OFF_W-1:0] ext_off;
    logic [OFF_W-1:0] off_sel;
    logic [OFF_W-1:0] room;
    logic [OFF_W-1:0] pad_x;
    logic [OFF_W-1:0] plen;
    logic             has_pad;
    logic             has_ext;

    assign has_pad  = hdr.first[5];
    assign has_ext  = hdr.first[4];
    assign len_x    = OFF_W'(len);
    assign base_off = OFF_W'(HDR_BYTES) + OFF_W'({hdr.first[3:0], 2'b00});
    assign ext_off  = base_off + OFF_W'(4) + OFF_W'({hdr.ext_len, 2'b00});
    assign off_sel  = has_ext ? ext_off : base_off;
    assign room     = len_x - off_sel;
    assign pad_x    = has_pad ? OFF_W'(pad) : '0;
    assign plen     = room - pad_x;

    always_comb
    begin
        res = '0;
        priority if (hdr.overflow || len > MAX_LEN)
            res.status = ST_MALFORMED;
        else if (len_x < OFF_W'(HDR_BYTES))
            res.status = ST_MALFORMED;
        else if (hdr.first[7:6] != RTP_VERSION)
            res.status = ST_BAD_VERSION;
        else if (len_x < base_off)
            res.status = ST_MALFORMED;
        else if (has_ext && len_x < base_off + OFF_W'(4))
            res.status = ST_MALFORMED;
        else if (has_ext && len_x < ext_off)
            res.status = ST_MALFORMED;
        else if (has_pad && (pad == 8'd0 || room < pad_x))
            res.status = ST_MALFORMED;
        else
        begin
            res.status         = ST_OK;
            res.marker_bit     = hdr.second[7];
            res.media_type     = hdr.second[6:0];
            res.sequence_res   = hdr.seq;
            res.timestamp      = hdr.tstamp;
            res.source_id      = hdr.ssrc;
            res.payload_offset = off_sel[15:0];
            res.payload_length = plen[15:0];
        end
    end

endmodule

[rtl/core/rtp_header_parser_top.sv]
// rtp fixed header parser, top level
//
// input channel: one datagram byte per transfer (data_byte, last_byte),
// handshake byte_valid / byte_stall. output channel: one result per
// datagram, loaded when its last byte leaves the input register,
// handshake res_valid / res_stall.
// a byte is registered on transfer, then counted and captured when it
// leaves the input register; on the last byte the checks run in that same
// cycle and the result register loads and offers the result.
// throughput is one byte per cycle while byte_stall is low, set by the byte
// counter and capture compare in the stage after the input register.
// bytes that are not last keep flowing while a result waits; byte_stall
// rises only when a last byte is registered and the previous result is
// still held by res_stall.
// reset clears the input valid, the header state and the result valid;
// the parser starts a new datagram after reset and after every last byte.
`include "assert_macros.svh"

module rtp_header_parser_top #(
    parameter int MAX_DATAGRAM_LEN = rhp_pkg::MAX_DATAGRAM_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic        marker_bit,
    output logic [6:0]  media_type,
    output logic [15:0] sequence_res,
    output logic [31:0] timestamp,
    output logic [31:0] source_id,
    output logic [15:0] payload_offset,
    output logic [15:0] payload_length
);
    import rhp_pkg::*;

    localparam int CNT_W = $clog2(MAX_DATAGRAM_LEN + 1);

    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [7:0]     s1_byte_reg;
    logic           s1_last_reg;
    logic           s1_hold;
    logic           s1_fire;
    logic           byte_xfer;
    logic           res_valid_reg;
    logic           res_valid_next;
    res_t           res_reg;
    res_t           res_now;
    held_t          hdr_now;
    logic [CNT_W:0] len_now;
    logic           res_err;
    logic           res_blank;

    assign s1_hold    = s1_valid_reg && s1_last_reg && res_valid_reg && res_stall;
    assign s1_fire    = s1_valid_reg && !s1_hold;
    assign byte_stall = s1_hold;
    assign byte_xfer  = byte_valid && !s1_hold;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!s1_hold)
            s1_valid_next = byte_valid;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_fire && s1_last_reg)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    rhp_capture #(
        .MAX_DATAGRAM_LEN (MAX_DATAGRAM_LEN),
        .CNT_W            (CNT_W)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .hdr_now   (hdr_now),
        .len_now   (len_now)
    );

    rhp_judge #(
        .MAX_DATAGRAM_LEN (MAX_DATAGRAM_LEN),
        .CNT_W            (CNT_W)
    ) u_judge (
        .hdr (hdr_now),
        .len (len_now),
        .pad (s1_byte_reg),
        .res (res_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_xfer)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_fire && s1_last_reg)
            res_reg <= res_now;
    end

    assign res_valid      = res_valid_reg;
    assign status         = res_reg.status;
    assign marker_bit     = res_reg.marker_bit;
    assign media_type     = res_reg.media_type;
    assign sequence_res   = res_reg.sequence_res;
    assign timestamp      = res_reg.timestamp;
    assign source_id      = res_reg.source_id;
    assign payload_offset = res_reg.payload_offset;
    assign payload_length = res_reg.payload_length;

    assign res_err   = res_valid && status != ST_OK;
    assign res_blank = payload_offset == 16'd0 && payload_length == 16'd0 && source_id == 32'd0;

    `ASSERT_IMPL(a_stall_only_on_full, clk, rst_n, byte_stall, res_valid && res_stall)
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_fire && s1_last_reg, res_valid)
    `ASSERT_IMPL(a_error_zero_fields, clk, rst_n, res_err, res_blank)

endmodule

[dv/rtp_header_parser_top_tb.sv]
// testbench for the rtp header parser: directed and random datagrams checked against a parser model
module rtp_header_parser_top_tb;

    import rhp_pkg::*;

    localparam int DGRAM_MAX = MAX_DATAGRAM_LEN_DEF;
    localparam int RANDOM_BYTES = 1175;
    localparam int QUIET_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  status;
    logic        marker_bit;
    logic [6:0]  media_type;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] source_id;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;

    res_t        seen;
    logic [7:0]  frame[$];
    int unsigned quiet = 0;

    assign seen = {status, marker_bit, media_type, sequence_res, timestamp, source_id,
                   payload_offset, payload_length};

    rtp_header_parser_top #(
        .MAX_DATAGRAM_LEN(DGRAM_MAX)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .status(status),
        .marker_bit(marker_bit),
        .media_type(media_type),
        .sequence_res(sequence_res),
        .timestamp(timestamp),
        .source_id(source_id),
        .payload_offset(payload_offset),
        .payload_length(payload_length)
    );

    class rtp_result_board;
        int unsigned count;
        bit          overflow;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [31:0] ssrc;
        logic [15:0] ext_len;
        res_t        awaited[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            count = 0;
            overflow = 1'b0;
            first = '0;
            second = '0;
            seq = '0;
            stamp = '0;
            ssrc = '0;
            ext_len = '0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function res_t classify(int unsigned len, logic [7:0] pad);
            res_t        r;
            int unsigned off;
            r = '0;
            r.status = ST_MALFORMED;
            if (overflow || len > DGRAM_MAX || len < HDR_BYTES)
                return r;
            if (first[7:6] != RTP_VERSION)
            begin
                r.status = ST_BAD_VERSION;
                return r;
            end
            off = HDR_BYTES + 4 * int'(first[3:0]);
            if (len < off)
                return r;
            if (first[4])
            begin
                if (len < off + 4)
                    return r;
                off = off + 4 + 4 * int'(ext_len);
                if (len < off)
                    return r;
            end
            if (first[5])
            begin
                if (pad == 8'd0 || len - off < pad)
                    return r;
                len = len - pad;
            end
            r.status = ST_OK;
            r.marker_bit = second[7];
            r.media_type = second[6:0];
            r.sequence_res = seq;
            r.timestamp = stamp;
            r.source_id = ssrc;
            r.payload_offset = off[15:0];
            r.payload_length = 16'(len - off);
            return r;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned idx;
            int unsigned len;
            int unsigned ext_at;
            idx = count;
            len = idx + 1;
            if (!overflow && len <= DGRAM_MAX)
            begin
                ext_at = HDR_BYTES + 4 * int'(first[3:0]) + 2;
                case (idx)
                    0: first = b;
                    1: second = b;
                    2, 3: seq = {seq[7:0], b};
                    4, 5, 6, 7: stamp = {stamp[23:0], b};
                    8, 9, 10, 11: ssrc = {ssrc[23:0], b};
                    default: ;
                endcase
                if (idx >= HDR_BYTES && (idx == ext_at || idx == ext_at + 1))
                    ext_len = {ext_len[7:0], b};
            end
            if (!last)
            begin
                if (len > DGRAM_MAX)
                    overflow = 1'b1;
                else
                    count = len;
                return;
            end
            awaited.push_back(classify(len, b));
            restart();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no datagram pending: status %0d", got.status);
                return;
            end
            want = awaited.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("marker_bit", 32'(want.marker_bit), 32'(got.marker_bit));
            check_field("media_type", 32'(want.media_type), 32'(got.media_type));
            check_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
            check_field("timestamp", want.timestamp, got.timestamp);
            check_field("source_id", want.source_id, got.source_id);
            check_field("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset));
            check_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
        endfunction
    endclass

    rtp_result_board board = new();

    always #10 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function void build_frame(logic [1:0] ver, bit pad_on, bit ext_on, int cc, int ext_decl,
                              int ext_body, int pay_n, int pad_n);
        frame.delete();
        frame.push_back({ver, pad_on, ext_on, 4'(cc)});
        repeat (11 + 4 * cc) frame.push_back(8'($urandom));
        if (ext_on)
        begin
            repeat (2) frame.push_back(8'($urandom));
            frame.push_back(8'(ext_decl >> 8));
            frame.push_back(8'(ext_decl));
            repeat (4 * ext_body) frame.push_back(8'($urandom));
        end
        repeat (pay_n) frame.push_back(8'($urandom));
        if (pad_on)
        begin
            repeat ((pad_n > 0) ? pad_n - 1 : 0) frame.push_back(8'($urandom));
            frame.push_back(8'(pad_n));
        end
    endfunction

    task automatic send_frame(input bit calm);
        int unsigned gap;
        foreach (frame[i])
        begin
            byte_valid <= 1'b1;
            data_byte <= frame[i];
            last_byte <= (i == frame.size() - 1);
            do @(posedge clk); while (byte_stall);
            gap = calm ? 0 : pick_gap();
            if (gap != 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold the sender until every pending result has come out
    task automatic drain();
        byte_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                board.check_result(seen);
            if (byte_valid && !byte_stall)
                board.take_byte(data_byte, last_byte);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (res_valid && !res_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int unsigned n;
        forever
        begin
            n = pick_gap();
            if (n != 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned frames;
        int unsigned kind;
        int unsigned cc;
        int unsigned ext_n;
        logic [1:0]  ver;
        bit          p;
        bit          x;
        bit          calm;

        sent = 0;
        frames = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // header fields all ones, then all zeros
        build_frame(2'd2, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 1; i < 12; i++)
            frame[i] = 8'hff;
        send_frame(0);
        build_frame(2'd2, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 1; i < 12; i++)
            frame[i] = 8'h00;
        send_frame(0);

        // short datagrams
        frame.delete();
        frame.push_back(8'h80);
        send_frame(0);
        build_frame(2'd2, 0, 0, 0, 0, 0, 0, 0);
        frame = frame[0:10];
        send_frame(0);

        // other versions
        for (int v = 0; v < 4; v++)
        begin
            if (v != RTP_VERSION)
            begin
                build_frame(2'(v), 0, 0, 0, 0, 0, 4, 0);
                send_frame(0);
            end
        end

        // csrc list full and cut short
        build_frame(2'd2, 0, 0, 15, 0, 0, 3, 0);
        send_frame(0);
        build_frame(2'd2, 0, 0, 3, 0, 0, 0, 0);
        frame = frame[0:16];
        send_frame(0);

        // extension header cut, body short, empty body, huge length word
        build_frame(2'd2, 0, 1, 0, 0, 0, 0, 0);
        frame = frame[0:13];
        send_frame(0);
        build_frame(2'd2, 0, 1, 0, 2, 1, 0, 0);
        send_frame(0);
        build_frame(2'd2, 0, 1, 0, 0, 0, 6, 0);
        send_frame(0);
        build_frame(2'd2, 0, 1, 0, 16'hffff, 0, 5, 0);
        send_frame(0);

        // padding count zero, too big, equal to the remainder, max value
        build_frame(2'd2, 1, 0, 0, 0, 0, 5, 0);
        send_frame(0);
        build_frame(2'd2, 1, 0, 0, 0, 0, 3, 2);
        frame[frame.size() - 1] = 8'd10;
        send_frame(0);
        build_frame(2'd2, 1, 0, 0, 0, 0, 0, 4);
        send_frame(0);
        build_frame(2'd2, 1, 0, 0, 0, 0, 10, 255);
        send_frame(0);

        // all flags together
        build_frame(2'd2, 1, 1, 15, 2, 2, 7, 3);
        frame[1][7] = 1'b1;
        send_frame(0);
        drain();

        while (sent < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            cc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            ext_n = $urandom_range(0, 3);
            p = 1'($urandom);
            x = 1'($urandom);
            build_frame(2'd2, p, x, cc, ext_n, ext_n, $urandom_range(0, 24), $urandom_range(1, 8));
            if (kind < 70)
                ;
            else if (kind < 78)
            begin
                ver = 2'($urandom_range(0, 2));
                if (ver == RTP_VERSION)
                    ver = 2'd3;
                frame[0][7:6] = ver;
            end
            else if (kind < 86)
                frame = frame[0:$urandom_range(0, frame.size() - 1)];
            else if (kind < 92)
            begin
                frame[0][5] = 1'b1;
                frame[frame.size() - 1] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
            end
            else if (kind < 96)
                build_frame(2'd2, p, 1, cc, $urandom_range(0, 65535), ext_n,
                            $urandom_range(0, 24), $urandom_range(1, 8));
            else
            begin
                frame.delete();
                repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
            end
            calm = ($urandom_range(0, 4) == 0);
            send_frame(calm);
            sent += frame.size();
            frames++;
            if (frames % 12 == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
